// ----- hw/rtl/fate_pkg.sv -----
// shared types, constants and controller/datapath interface for the trace engine
package fate_pkg;

  localparam int NUM_STATES      = 32;
  localparam int MAX_TRANSITIONS = 64;
  localparam int STATE_W         = $clog2(NUM_STATES);
  localparam int ENTRY_IDX_W     = $clog2(MAX_TRANSITIONS);
  localparam int ENTRY_CNT_W     = $clog2(MAX_TRANSITIONS + 1);
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 7;

  localparam logic [1:0] ACT_LOAD    = 2'd0;
  localparam logic [1:0] ACT_RESTART = 2'd1;
  localparam logic [1:0] ACT_SYMBOL  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_START_STATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DFA_MODE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_USED  = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [5:0]  entry_index;
    logic [4:0]  from_state;
    logic [4:0]  to_state;
    logic [7:0]  label_byte;
    logic        label_is_epsilon;
    logic [7:0]  symbol;
  } in_word_t;

  typedef struct packed {
    logic [31:0] active_set;
    logic        is_dead;
  } out_word_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_WRITE,
    CMD_START_SET,
    CMD_CLEAR_SET,
    CMD_MOVE_SETUP,
    CMD_SCAN,
    CMD_TAKE_MOVE,
    CMD_COMMIT
  } cmd_op_t;

  typedef enum logic [1:0] {
    SCAN_MOVE,
    SCAN_CLOSE,
    SCAN_DFA
  } scan_kind_t;

  typedef struct packed {
    cmd_op_t    op;
    scan_kind_t kind;
    logic       capture;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic changed;
    logic dead;
    logic dfa_mode;
  } status_t;

endpackage

// ----- hw/rtl/finite_automaton_trace_engine.sv -----
// Finite automaton trace engine. A load word gives no result. A restart word in DFA mode
// goes from acceptance straight to the commit state, which raises done; in NFA mode it runs
// epsilon closure passes. A symbol word in NFA mode runs one move pass over the table, then
// closure passes until a pass adds no state; in DFA mode one first-match pass. Each pass reads
// the entries in use through the table's single read port, which yields one entry per cycle;
// the number of closure passes is at most one more than the states added. A symbol word on a
// dead automaton also goes from acceptance straight to the commit state and done.
// busy is high from acceptance until the result strobe; done marks result for one cycle and
// cannot be held off by the receiver.
module finite_automaton_trace_engine import fate_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  start,
  input  in_word_t              item,
  output logic                  busy,
  output logic                  done,
  output out_word_t             result
);

  cmd_t    cmd;
  status_t status;

  fate_controller u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  fate_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .item     (item),
    .cmd      (cmd),
    .status   (status),
    .done     (done),
    .result   (result)
  );

endmodule

// ----- hw/rtl/fate_controller.sv -----
// sequencer for load, restart and symbol words: move or first-match pass, closure passes, commit
module fate_controller import fate_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  in_word_t item,
  input  status_t  status,
  output cmd_t     cmd,
  output logic     busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOVE_GO,
    S_MOVE_WAIT,
    S_CLOSE_GO,
    S_CLOSE_WAIT,
    S_DFA_GO,
    S_DFA_WAIT,
    S_COMMIT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next  = state;
    cmd.op      = CMD_NONE;
    cmd.kind    = SCAN_MOVE;
    cmd.capture = 1'b0;
    case (state)
      S_IDLE: begin
        if (start && !busy) begin
          cmd.capture = 1'b1;
          case (item.action)
            ACT_LOAD: begin
              cmd.op = CMD_WRITE;
            end
            ACT_RESTART: begin
              cmd.op     = CMD_START_SET;
              state_next = status.dfa_mode ? S_COMMIT : S_CLOSE_GO;
            end
            ACT_SYMBOL: begin
              if (status.dead) begin
                cmd.op     = CMD_CLEAR_SET;
                state_next = S_COMMIT;
              end else begin
                cmd.op     = CMD_MOVE_SETUP;
                state_next = status.dfa_mode ? S_DFA_GO : S_MOVE_GO;
              end
            end
            default: begin
              cmd.op = CMD_NONE;
            end
          endcase
        end
      end
      S_MOVE_GO: begin
        cmd.op     = CMD_SCAN;
        cmd.kind   = SCAN_MOVE;
        state_next = S_MOVE_WAIT;
      end
      S_MOVE_WAIT: begin
        if (status.scan_done) begin
          cmd.op     = CMD_TAKE_MOVE;
          state_next = S_CLOSE_GO;
        end
      end
      S_CLOSE_GO: begin
        cmd.op     = CMD_SCAN;
        cmd.kind   = SCAN_CLOSE;
        state_next = S_CLOSE_WAIT;
      end
      S_CLOSE_WAIT: begin
        // another pass only while the last one grew the set
        if (status.scan_done) begin
          state_next = status.changed ? S_CLOSE_GO : S_COMMIT;
        end
      end
      S_DFA_GO: begin
        cmd.op     = CMD_SCAN;
        cmd.kind   = SCAN_DFA;
        state_next = S_DFA_WAIT;
      end
      S_DFA_WAIT: begin
        if (status.scan_done) begin
          cmd.op     = CMD_TAKE_MOVE;
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.op     = CMD_COMMIT;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

// ----- hw/rtl/fate_datapath.sv -----
// configuration registers, transition table, scan engine and active set
module fate_datapath import fate_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  in_word_t              item,
  input  cmd_t                  cmd,
  output status_t               status,
  output logic                  done,
  output out_word_t             result
);

  typedef struct packed {
    logic               eps;
    logic [7:0]         label;
    logic [STATE_W-1:0] dst;
    logic [STATE_W-1:0] src;
  } entry_t;

  logic [STATE_W-1:0]     start_state;
  logic                   dfa_mode;
  logic [ENTRY_CNT_W-1:0] trans_used;
  logic [ENTRY_CNT_W-1:0] n_used;

  entry_t                 mem [MAX_TRANSITIONS];
  entry_t                 rd_entry;
  logic                   rd_valid;
  logic                   scanning;
  logic                   scan_done;
  logic [ENTRY_CNT_W-1:0] idx;
  logic                   fetch;
  scan_kind_t             kind;

  logic [NUM_STATES-1:0]  active_mask;
  logic                   dead;
  logic [NUM_STATES-1:0]  work_set;
  logic [NUM_STATES-1:0]  acc;
  logic [STATE_W-1:0]     cur;
  logic                   found;
  logic                   changed;
  logic [7:0]             sym;
  logic [1:0]             act;

  function automatic logic [STATE_W-1:0] lowest_set(input logic [NUM_STATES-1:0] v);
    logic [STATE_W-1:0] r;
    r = '0;
    for (int i = NUM_STATES - 1; i >= 0; i--) begin
      if (v[i]) r = STATE_W'(i);
    end
    return r;
  endfunction

  assign n_used = (trans_used > ENTRY_CNT_W'(MAX_TRANSITIONS)) ?
                  ENTRY_CNT_W'(MAX_TRANSITIONS) : trans_used;
  assign fetch  = scanning && (idx < n_used);

  assign status.scan_done = scan_done;
  assign status.changed   = changed;
  assign status.dead      = dead;
  assign status.dfa_mode  = dfa_mode;

  // control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      start_state <= '0;
      dfa_mode    <= 1'b0;
      trans_used  <= '0;
      scanning    <= 1'b0;
      rd_valid    <= 1'b0;
      scan_done   <= 1'b0;
      idx         <= '0;
      active_mask <= '0;
      dead        <= 1'b0;
      done        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_START_STATE: start_state <= cfg_data[STATE_W-1:0];
          REG_DFA_MODE:    dfa_mode    <= cfg_data[0];
          REG_TRANS_USED:  trans_used  <= cfg_data[ENTRY_CNT_W-1:0];
          default:         ;
        endcase
      end
      scan_done <= 1'b0;
      done      <= 1'b0;
      if (cmd.op == CMD_SCAN) begin
        scanning <= 1'b1;
        idx      <= '0;
        rd_valid <= 1'b0;
      end else if (scanning) begin
        if (fetch) begin
          rd_valid <= 1'b1;
          idx      <= idx + ENTRY_CNT_W'(1);
        end else begin
          // last entry is folded in on this edge, so done shows next cycle
          scanning  <= 1'b0;
          rd_valid  <= 1'b0;
          scan_done <= 1'b1;
        end
      end else begin
        rd_valid <= 1'b0;
      end
      if (cmd.op == CMD_COMMIT) begin
        active_mask <= work_set;
        dead        <= (act == ACT_RESTART) ? (work_set == '0) : (dead || work_set == '0);
        done        <= 1'b1;
      end
    end
  end

  // transition table, one write or one read a cycle
  always_ff @(posedge clk) begin
    if (cmd.op == CMD_WRITE) begin
      mem[item.entry_index[ENTRY_IDX_W-1:0]] <= '{eps:   item.label_is_epsilon,
                                                 label: item.label_byte,
                                                 dst:   item.to_state,
                                                 src:   item.from_state};
    end
    if (fetch) begin
      rd_entry <= mem[idx[ENTRY_IDX_W-1:0]];
    end
  end

  // working sets and per-entry update
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sym <= item.symbol;
      act <= item.action;
    end
    case (cmd.op)
      CMD_START_SET: work_set <= NUM_STATES'(1) << start_state;
      CMD_CLEAR_SET: work_set <= '0;
      CMD_MOVE_SETUP: begin
        work_set <= active_mask;
        acc      <= '0;
        found    <= 1'b0;
        cur      <= lowest_set(active_mask);
      end
      CMD_SCAN: begin
        changed <= 1'b0;
        kind    <= cmd.kind;
      end
      CMD_TAKE_MOVE: work_set <= acc;
      CMD_COMMIT: begin
        result.active_set <= work_set;
        result.is_dead    <= (work_set == '0);
      end
      default: ;
    endcase
    if (rd_valid) begin
      case (kind)
        SCAN_MOVE: begin
          if (!rd_entry.eps && rd_entry.label == sym && work_set[rd_entry.src]) begin
            acc[rd_entry.dst] <= 1'b1;
          end
        end
        SCAN_CLOSE: begin
          if (rd_entry.eps && work_set[rd_entry.src] && !work_set[rd_entry.dst]) begin
            work_set[rd_entry.dst] <= 1'b1;
            changed                <= 1'b1;
          end
        end
        SCAN_DFA: begin
          // first match in table order wins; an empty set has no current state
          if (!found && work_set[cur] && !rd_entry.eps && rd_entry.label == sym &&
              rd_entry.src == cur) begin
            found <= 1'b1;
            acc   <= NUM_STATES'(1) << rd_entry.dst;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- tb/tb_finite_automaton_trace_engine.sv -----
// self-checking testbench for the finite automaton trace engine
`timescale 1ns / 1ps

module tb_finite_automaton_trace_engine;
  import fate_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int LIMIT = 12_000_000;

  typedef struct packed {
    logic       eps;
    logic [7:0] lbl;
    logic [4:0] dst;
    logic [4:0] src;
  } arc_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  start = 1'b0;
  in_word_t              item = '0;
  logic                  busy;
  logic                  done;
  out_word_t             result;

  finite_automaton_trace_engine uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .start    (start),
    .item     (item),
    .busy     (busy),
    .done     (done),
    .result   (result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  arc_t        trans_tbl [MAX_TRANSITIONS];
  logic [31:0] live_set = '0;
  logic        is_dead_now = 1'b0;
  logic [4:0]  start_reg = '0;
  logic        dfa_reg = 1'b0;
  logic [6:0]  used_reg = '0;

  in_word_t  pending_words [$];
  out_word_t expected_sets [$];
  out_word_t want;

  logic [4:0] window_base = '0;
  logic [7:0] alphabet [4];
  bit         steady = 1'b0;
  int         gap = 0;
  int         errors = 0;
  int         loads_seen = 0;
  int         restarts_seen = 0;
  int         symbols_seen = 0;
  int         results_checked = 0;
  int         dead_results = 0;

  function automatic void queue_word(input in_word_t w);
    pending_words = {pending_words, w};
  endfunction

  function automatic int live_entries();
    return (used_reg > MAX_TRANSITIONS) ? MAX_TRANSITIONS : int'(used_reg);
  endfunction

  function automatic logic [31:0] close_over_eps(input logic [31:0] set);
    logic [31:0] cur;
    bit          grew;
    cur  = set;
    grew = 1'b1;
    while (grew) begin
      grew = 1'b0;
      for (int i = 0; i < live_entries(); i++) begin
        if (trans_tbl[i].eps && cur[trans_tbl[i].src] && !cur[trans_tbl[i].dst]) begin
          cur[trans_tbl[i].dst] = 1'b1;
          grew = 1'b1;
        end
      end
    end
    return cur;
  endfunction

  function automatic logic [31:0] move_on_symbol(input logic [31:0] set, input logic [7:0] sym);
    logic [31:0] nxt;
    nxt = '0;
    for (int i = 0; i < live_entries(); i++) begin
      if (!trans_tbl[i].eps && trans_tbl[i].lbl == sym && set[trans_tbl[i].src])
        nxt[trans_tbl[i].dst] = 1'b1;
    end
    return nxt;
  endfunction

  // deterministic walk from the lowest active state, epsilon arcs never match
  function automatic logic [31:0] first_match_move(input logic [31:0] set, input logic [7:0] sym);
    int cur;
    if (set == '0) return '0;
    cur = 0;
    while (!set[cur]) cur++;
    for (int i = 0; i < live_entries(); i++) begin
      if (!trans_tbl[i].eps && trans_tbl[i].lbl == sym && trans_tbl[i].src == cur)
        return 32'd1 << trans_tbl[i].dst;
    end
    return '0;
  endfunction

  function automatic void apply_word(input in_word_t w);
    out_word_t r;
    if (w.action == ACT_LOAD) begin
      trans_tbl[w.entry_index].src = w.from_state;
      trans_tbl[w.entry_index].dst = w.to_state;
      trans_tbl[w.entry_index].lbl = w.label_byte;
      trans_tbl[w.entry_index].eps = w.label_is_epsilon;
      loads_seen++;
      return;
    end
    if (w.action == ACT_RESTART) begin
      live_set    = dfa_reg ? (32'd1 << start_reg) : close_over_eps(32'd1 << start_reg);
      is_dead_now = (live_set == '0);
      restarts_seen++;
    end else if (w.action == ACT_SYMBOL) begin
      if (is_dead_now)
        live_set = '0;
      else if (dfa_reg)
        live_set = first_match_move(live_set, w.symbol);
      else
        live_set = close_over_eps(move_on_symbol(live_set, w.symbol));
      if (live_set == '0) is_dead_now = 1'b1;
      symbols_seen++;
    end else begin
      return;
    end
    r.active_set = live_set;
    r.is_dead    = (live_set == '0);
    expected_sets = {expected_sets, r};
  endfunction

  // idle cycles before the next word, each further one taken with a 36 in 100 chance
  function automatic int pick_gap();
    int n;
    n = 0;
    if (steady) return 0;
    while ($urandom_range(0, 99) < 36) n++;
    return n;
  endfunction

  function automatic in_word_t noise_word();
    in_word_t w;
    w.action           = 2'($urandom_range(0, 3));
    w.entry_index      = 6'($urandom_range(0, 63));
    w.from_state       = 5'($urandom_range(0, 31));
    w.to_state         = 5'($urandom_range(0, 31));
    w.label_byte       = 8'($urandom_range(0, 255));
    w.label_is_epsilon = 1'($urandom_range(0, 1));
    w.symbol           = 8'($urandom_range(0, 255));
    return w;
  endfunction

  // states cluster round the start state so that walks stay alive
  function automatic logic [4:0] near_state();
    if ($urandom_range(0, 99) < 85) return window_base + 5'($urandom_range(0, 7));
    return 5'($urandom_range(0, 31));
  endfunction

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 99) < 85) return alphabet[$urandom_range(0, 3)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic in_word_t make_load(input int slot);
    in_word_t w;
    w                  = noise_word();
    w.action           = ACT_LOAD;
    w.entry_index      = 6'(slot);
    w.from_state       = near_state();
    w.to_state         = near_state();
    w.label_byte       = pick_byte();
    w.label_is_epsilon = ($urandom_range(0, 3) == 0);
    return w;
  endfunction

  function automatic in_word_t make_entry(input int slot, input int src, input int dst,
                                          input int lbl, input bit eps);
    in_word_t w;
    w                  = noise_word();
    w.action           = ACT_LOAD;
    w.entry_index      = 6'(slot);
    w.from_state       = 5'(src);
    w.to_state         = 5'(dst);
    w.label_byte       = 8'(lbl);
    w.label_is_epsilon = eps;
    return w;
  endfunction

  function automatic in_word_t make_cmd(input logic [1:0] act, input int sym);
    in_word_t w;
    w        = noise_word();
    w.action = act;
    if (sym >= 0) w.symbol = 8'(sym);
    else if (act == ACT_SYMBOL) w.symbol = pick_byte();
    return w;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      REG_START_STATE: start_reg = val[4:0];
      REG_DFA_MODE:    dfa_reg   = val[0];
      REG_TRANS_USED:  used_reg  = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // idle: nothing queued or presented, every result back, then room for a trailing load
  task automatic settle();
    while (pending_words.size() != 0 || start || expected_sets.size() != 0 || busy)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap   <= 0;
    end else begin
      if (start && !busy) apply_word(item);
      if (!start || !busy) begin
        if (gap > 0) begin
          // idle cycles only count once the engine is free again
          start <= 1'b0;
          if (!busy) gap <= gap - 1;
        end else if (pending_words.size() > 0) begin
          item  <= pending_words.pop_front();
          start <= 1'b1;
          gap   <= pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_sets.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual set %h dead %b",
                 $time, result.active_set, result.is_dead);
        errors++;
      end else begin
        want = expected_sets.pop_front();
        if (result.active_set !== want.active_set) begin
          $display("%0t: active_set expected %h actual %h", $time, want.active_set,
                   result.active_set);
          errors++;
        end
        if (result.is_dead !== want.is_dead) begin
          $display("%0t: is_dead expected %b actual %b", $time, want.is_dead, result.is_dead);
          errors++;
        end
        if (want.is_dead) dead_results++;
        results_checked++;
      end
    end
  end

  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("timeout with %0d words still expected", expected_sets.size());
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int st, dm, tu, n, k, r;
    for (int i = 0; i < 4; i++) alphabet[i] = 8'($urandom_range(0, 255));
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // empty table in use: symbol before any restart, lone start state, dead words, unused code
    queue_word(make_cmd(ACT_SYMBOL, 8'hff));
    queue_word(make_cmd(ACT_RESTART, -1));
    queue_word(make_cmd(ACT_SYMBOL, 8'h00));
    queue_word(make_cmd(ACT_SYMBOL, 8'h55));
    queue_word(make_cmd(ACT_UNUSED, -1));
    queue_word(make_cmd(ACT_RESTART, -1));
    settle();

    // hand-built head of the table, random tail
    queue_word(make_entry(0, 0, 1, 8'haa, 1'b1));
    queue_word(make_entry(1, 1, 2, 8'h00, 1'b1));
    queue_word(make_entry(2, 2, 3, 8'h00, 1'b0));
    queue_word(make_entry(3, 0, 31, 8'hff, 1'b0));
    queue_word(make_entry(4, 31, 30, 8'hff, 1'b1));
    queue_word(make_entry(5, 1, 4, 8'h00, 1'b0));
    queue_word(make_entry(6, 0, 9, 8'h55, 1'b1));
    queue_word(make_entry(7, 0, 8, 8'h55, 1'b0));
    window_base = 5'd16;
    for (int i = 8; i < MAX_TRANSITIONS; i++) queue_word(make_load(i));
    settle();
    write_reg(REG_TRANS_USED, 7'd8);

    queue_word(make_cmd(ACT_RESTART, -1));
    queue_word(make_cmd(ACT_SYMBOL, 8'h00));
    queue_word(make_cmd(ACT_SYMBOL, 8'h00));
    queue_word(make_cmd(ACT_SYMBOL, 8'hff));
    queue_word(make_cmd(ACT_RESTART, -1));
    queue_word(make_cmd(ACT_SYMBOL, 8'hff));
    queue_word(make_cmd(ACT_RESTART, -1));
    queue_word(make_cmd(ACT_SYMBOL, 8'h55));
    settle();

    // deterministic walk, epsilon arc skipped
    write_reg(REG_DFA_MODE, 7'd1);
    queue_word(make_cmd(ACT_RESTART, -1));
    queue_word(make_cmd(ACT_SYMBOL, 8'h55));
    queue_word(make_cmd(ACT_RESTART, -1));
    queue_word(make_cmd(ACT_SYMBOL, 8'hff));
    queue_word(make_cmd(ACT_SYMBOL, 8'h00));
    settle();

    // several states active when the mode flips to deterministic
    write_reg(REG_DFA_MODE, 7'd0);
    queue_word(make_cmd(ACT_RESTART, -1));
    settle();
    write_reg(REG_DFA_MODE, 7'd1);
    queue_word(make_cmd(ACT_SYMBOL, 8'h55));
    settle();

    for (int p = 0; p < 8; p++) begin
      st = $urandom_range(0, 31);
      tu = 64;
      case (p)
        0: begin st = 0;  dm = 0; end
        1: begin st = 31; dm = 0; tu = 127; end
        2: dm = 1;
        3: begin st = 31; dm = 1; tu = 1; end
        4: begin dm = 0; tu = $urandom_range(2, 64); end
        5: begin dm = 1; tu = 127; end
        6: begin st = 0;  dm = 0; tu = 0; end
        default: dm = 0;
      endcase
      write_reg(REG_START_STATE, 7'(st));
      write_reg(REG_DFA_MODE, 7'(dm));
      write_reg(REG_TRANS_USED, 7'(tu));
      window_base = 5'(st);
      for (int i = 0; i < 4; i++) alphabet[i] = 8'($urandom_range(0, 255));
      steady = (p == 3);
      for (int i = 0; i < MAX_TRANSITIONS; i++) queue_word(make_load(i));
      n = 0;
      while (n < 76) begin
        queue_word(make_cmd(ACT_RESTART, -1));
        k = $urandom_range(1, 8);
        repeat (k) queue_word(make_cmd(ACT_SYMBOL, -1));
        n += k + 1;
        r = $urandom_range(0, 99);
        if (r < 20)
          queue_word(make_load($urandom_range(0, MAX_TRANSITIONS - 1)));
        else if (r < 27)
          queue_word(make_cmd(ACT_UNUSED, -1));
        else if (r < 35)
          queue_word(make_cmd(ACT_SYMBOL, $urandom_range(0, 255)));
      end
      settle();
    end

    $display("%0d loads, %0d restarts, %0d symbols over 8 random settings in both modes",
             loads_seen, restarts_seen, symbols_seen);
    $display("%0d result words checked, %0d of them dead", results_checked, dead_results);
    if (errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- finite_automaton_trace_engine.f -----
hw/rtl/fate_pkg.sv
hw/rtl/fate_controller.sv
hw/rtl/fate_datapath.sv
hw/rtl/finite_automaton_trace_engine.sv
tb/tb_finite_automaton_trace_engine.sv
